[rtl/prh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polynomial rolling hash package
// Shared widths, register indexes, payload types and sequencer states.
// ----------------------------------------------------------------------------
package prh_pkg;

  localparam int HashW   = 64;
  localparam int ByteW   = 8;
  localparam int CfgIdxW = 2;
  localparam int CntW    = $clog2(HashW);

  localparam logic [CfgIdxW-1:0] CfgIdxBase    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdxModulus = CfgIdxW'(1);

  localparam logic [HashW-1:0] BaseReset    = HashW'(31);
  localparam logic [HashW-1:0] ModulusReset = '0;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } in_item_t;

  typedef struct packed {
    logic [HashW-1:0] hash_value;
    logic             hash_final;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_status_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_RED_X,
    ENG_MUL_DBL,
    ENG_MUL_ADD,
    ENG_RED_B,
    ENG_ADD,
    ENG_DONE
  } eng_state_e;

endpackage

[rtl/prh_modadd.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular adder
// Adds two operands whose sum stays below twice the modulus and reduces the
// result with one conditional subtraction. A zero modulus gives 64-bit wrap.
// ----------------------------------------------------------------------------
module prh_modadd
  import prh_pkg::*;
(
  input  logic [HashW:0]   p_i,
  input  logic [HashW-1:0] q_i,
  input  logic [HashW-1:0] mod_i,
  output logic [HashW-1:0] res_o
);

  logic [HashW:0] sum;
  logic [HashW:0] diff;
  logic           over;

  always_comb begin
    sum  = p_i + {1'b0, q_i};
    diff = sum - {1'b0, mod_i};
    over = (mod_i != '0) && (sum >= {1'b0, mod_i});
    res_o = over ? diff[HashW-1:0] : sum[HashW-1:0];
  end

endmodule

[rtl/prh_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash step engine
// Sequences the shared modular adder through reductions of the running hash
// and the byte, an MSB-first multiply by the base and the byte addition.
// ----------------------------------------------------------------------------
module prh_engine
  import prh_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             emit_i,
  input  logic [HashW-1:0] hash_i,
  input  logic [HashW-1:0] base_i,
  input  logic [HashW-1:0] mod_i,
  input  logic [ByteW-1:0] byte_i,
  output eng_status_t      status_o,
  output logic [HashW-1:0] result_o
);

  eng_state_e       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [HashW-1:0] acc_q, acc_d;
  logic [HashW-1:0] xr_q, xr_d;
  logic [ByteW-1:0] byte_q;

  logic [HashW:0]   op_p;
  logic [HashW-1:0] op_q;
  logic [HashW-1:0] op_res;
  logic [HashW-1:0] byte_ext;
  logic             byte_red;
  logic             hash_red;

  prh_modadd u_modadd (
    .p_i   (op_p),
    .q_i   (op_q),
    .mod_i (mod_i),
    .res_o (op_res)
  );

  assign byte_ext = {{(HashW-ByteW){1'b0}}, byte_q};
  assign byte_red = (mod_i != '0) && (byte_ext >= mod_i);
  assign hash_red = (mod_i != '0) && (hash_i >= mod_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ENG_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    xr_q  <= xr_d;
    if (start_i) begin
      byte_q <= byte_i;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    xr_d    = xr_q;
    op_p    = {1'b0, acc_q};
    op_q    = '0;
    status_o.busy = (state_q != ENG_IDLE);
    status_o.done = (state_q == ENG_DONE);

    case (state_q)
      ENG_IDLE: begin
        if (start_i) begin
          acc_d = '0;
          cnt_d = CntW'(HashW-1);
          if (hash_red) begin
            state_d = ENG_RED_X;
          end else begin
            xr_d    = hash_i;
            state_d = ENG_MUL_DBL;
          end
        end
      end
      ENG_RED_X: begin
        // Restoring remainder, one bit of the running hash per cycle.
        op_p  = {acc_q, hash_i[cnt_q]};
        acc_d = op_res;
        if (cnt_q == '0) begin
          xr_d    = op_res;
          acc_d   = '0;
          cnt_d   = CntW'(HashW-1);
          state_d = ENG_MUL_DBL;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ENG_MUL_DBL: begin
        op_q  = acc_q;
        acc_d = op_res;
        if (base_i[cnt_q]) begin
          state_d = ENG_MUL_ADD;
        end else if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end else begin
          cnt_d = CntW'(ByteW-1);
          if (byte_red) begin
            xr_d    = '0;
            state_d = ENG_RED_B;
          end else begin
            xr_d    = byte_ext;
            state_d = ENG_ADD;
          end
        end
      end
      ENG_MUL_ADD: begin
        op_q  = xr_q;
        acc_d = op_res;
        if (cnt_q != '0) begin
          cnt_d   = cnt_q - 1'b1;
          state_d = ENG_MUL_DBL;
        end else begin
          cnt_d = CntW'(ByteW-1);
          if (byte_red) begin
            xr_d    = '0;
            state_d = ENG_RED_B;
          end else begin
            xr_d    = byte_ext;
            state_d = ENG_ADD;
          end
        end
      end
      ENG_RED_B: begin
        op_p = {xr_q, byte_q[cnt_q[$clog2(ByteW)-1:0]]};
        xr_d = op_res;
        if (cnt_q == '0) begin
          state_d = ENG_ADD;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ENG_ADD: begin
        op_q    = xr_q;
        acc_d   = op_res;
        state_d = ENG_DONE;
      end
      ENG_DONE: begin
        if (emit_i) begin
          state_d = ENG_IDLE;
        end
      end
      default: begin
        state_d = ENG_IDLE;
      end
    endcase
  end

  assign result_o = acc_q;

endmodule

[rtl/polynomial_rolling_hash_unit.sv]
// Per byte: reduction of the running hash when it is not below the modulus,
// the multiply loop, likewise a reduction of the byte, and the addition.
// One byte is in flight at a time; the multiply loop, one doubling per base
// bit and one addition per set base bit, sets the rate.
// Reset clears the running hash and loads base 31 and modulus 0.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polynomial rolling hash unit
// Horner-scheme hash over a byte stream with a programmable base and modulus.
// ----------------------------------------------------------------------------
module polynomial_rolling_hash_unit
  import prh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Byte stream in
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  // Hash results out
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  // Register writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [HashW-1:0]   cfg_data_i
);

  logic [HashW-1:0] base_q;
  logic [HashW-1:0] mod_q;
  logic [HashW-1:0] hash_q;
  logic             last_q;
  logic             out_valid_q;
  out_item_t        out_q;

  eng_status_t      eng_status;
  logic [HashW-1:0] eng_result;
  logic             in_accept;
  logic             emit;

  // Register writes are always taken. Software must write only while the unit
  // is idle (not enforced here), so the engine sees stable operands throughout.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseReset;
      mod_q  <= ModulusReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgIdxBase:    base_q <= cfg_data_i;
        CfgIdxModulus: mod_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The engine refuses new bytes from the moment it starts until its result
  // has moved into the output register. A waiting result in that register
  // does not hold up the next byte.
  assign in_stall_o = eng_status.busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  // The finished hash leaves the engine once the output register is free or
  // is being emptied in this cycle.
  assign emit = eng_status.done && (!out_valid_q || !out_stall_i);

  prh_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_accept),
    .emit_i   (emit),
    .hash_i   (hash_q),
    .base_i   (base_q),
    .mod_i    (mod_q),
    .byte_i   (in_data_i.data_byte),
    .status_o (eng_status),
    .result_o (eng_result)
  );

  // The running hash is replaced only when a result is handed on, and it
  // returns to zero after the last byte of a message.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        hash_q      <= last_q ? '0 : eng_result;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      last_q <= in_data_i.last_byte;
    end
    if (emit) begin
      out_q.hash_value <= eng_result;
      out_q.hash_final <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[tb/sv/tb_polynomial_rolling_hash_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polynomial rolling hash unit testbench
// Drives byte streams with random gaps and stalls into the hash unit,
// predicts each running hash independently and checks every result in order.
// ----------------------------------------------------------------------------
module tb_polynomial_rolling_hash_unit;
  import prh_pkg::*;

  // Register indexes that decode to nothing. Writes to them must leave both
  // the base and the modulus untouched.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare2 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgIdxSpare3 = CfgIdxW'(3);

  // Run sizing. The slowest byte reduces hash and byte and runs the full
  // multiply loop; both sides may idle at random before each item. About a
  // thousand bytes therefore finish well inside a quarter of the cycle limit.
  localparam int unsigned RandomBytes = 1000;
  localparam int unsigned LongHold    = 600;
  localparam int unsigned SettleWait  = 250;
  localparam int unsigned CycleLimit  = 2_000_000;

  // The directed table mixes byte transactions and register writes.
  typedef enum logic {
    ROW_BYTE,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [HashW-1:0]   value;
    logic [ByteW-1:0]   data;
    logic               last;
    logic               typed;
    logic [HashW-1:0]   typed_hash;
  } dir_row_t;

  localparam int unsigned DirRows = 34;
  localparam logic [HashW-1:0] AllOnes = '1;
  localparam logic [HashW-1:0] TopBit  = {1'b1, {(HashW-1){1'b0}}};

  // Rows with typed = 1 carry a hash that is obvious by hand. The remaining
  // rows are checked against the predictor alone.
  dir_row_t dir_rows [0:DirRows-1] = '{
    // Reset settings: base 31, plain 64-bit wrap.
    '{ROW_BYTE, CfgIdxBase,    '0,      8'h00, 1'b0, 1'b1, 64'd0},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'hFF, 1'b1, 1'b1, 64'd255},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'h01, 1'b0, 1'b1, 64'd1},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'h02, 1'b1, 1'b1, 64'd33},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'hFF, 1'b0, 1'b1, 64'd255},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'h80, 1'b0, 1'b0, 64'd0},
    // A modulus of one forces every hash to zero, even mid-message.
    '{ROW_REG,  CfgIdxModulus, 64'd1,   8'h00, 1'b0, 1'b0, 64'd0},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'hAA, 1'b0, 1'b1, 64'd0},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'h55, 1'b1, 1'b1, 64'd0},
    // Largest base with wrap-around: 255 * (2^64 - 1) wraps to -255.
    '{ROW_REG,  CfgIdxBase,    AllOnes, 8'h00, 1'b0, 1'b0, 64'd0},
    '{ROW_REG,  CfgIdxModulus, 64'd0,   8'h00, 1'b0, 1'b0, 64'd0},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'hFF, 1'b0, 1'b1, 64'd255},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'h00, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FF01},
    // Largest modulus equals the base, so the product vanishes.
    '{ROW_REG,  CfgIdxModulus, AllOnes, 8'h00, 1'b0, 1'b0, 64'd0},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'hFF, 1'b0, 1'b1, 64'd255},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'h7F, 1'b1, 1'b1, 64'd127},
    // Base zero: each hash is simply the byte.
    '{ROW_REG,  CfgIdxBase,    64'd0,   8'h00, 1'b0, 1'b0, 64'd0},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'h12, 1'b0, 1'b1, 64'h12},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'h34, 1'b1, 1'b1, 64'h34},
    // Build a large running hash, then shrink the modulus mid-message so the
    // stored hash has to be reduced before the multiply.
    '{ROW_REG,  CfgIdxBase,    64'hDEAD_BEEF_0123_4567, 8'h00, 1'b0, 1'b0, 64'd0},
    '{ROW_REG,  CfgIdxModulus, 64'd0,   8'h00, 1'b0, 1'b0, 64'd0},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'hC3, 1'b0, 1'b0, 64'd0},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'h5A, 1'b0, 1'b0, 64'd0},
    '{ROW_REG,  CfgIdxModulus, 64'd251, 8'h00, 1'b0, 1'b0, 64'd0},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'hFE, 1'b0, 1'b0, 64'd0},
    // Modulus below the byte value.
    '{ROW_REG,  CfgIdxModulus, 64'd7,   8'h00, 1'b0, 1'b0, 64'd0},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'hFF, 1'b0, 1'b0, 64'd0},
    // Writes to undecoded indexes are dropped.
    '{ROW_REG,  CfgIdxSpare2,  AllOnes, 8'h00, 1'b0, 1'b0, 64'd0},
    '{ROW_REG,  CfgIdxSpare3,  64'd0,   8'h00, 1'b0, 1'b0, 64'd0},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'h01, 1'b1, 1'b0, 64'd0},
    // Top-bit modulus with the largest base.
    '{ROW_REG,  CfgIdxBase,    AllOnes, 8'h00, 1'b0, 1'b0, 64'd0},
    '{ROW_REG,  CfgIdxModulus, TopBit,  8'h00, 1'b0, 1'b0, 64'd0},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'hFF, 1'b0, 1'b0, 64'd0},
    '{ROW_BYTE, CfgIdxBase,    '0,      8'h80, 1'b1, 1'b0, 64'd0}
  };

  // --------------------------------------------------------------------------
  // Clock, reset and the signals around the unit. Every input starts known.
  // --------------------------------------------------------------------------
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  in_item_t           in_data   = '0;
  logic               out_stall = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [HashW-1:0]   cfg_data  = '0;
  logic               in_stall;
  logic               out_valid;
  out_item_t          out_data;
  logic               cfg_ready;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  polynomial_rolling_hash_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state. It mirrors the registers and the running hash, and is
  // only ever touched at the clock edge where a transaction is accepted.
  // --------------------------------------------------------------------------
  logic [HashW-1:0] hash_base_q = BaseReset;
  logic [HashW-1:0] hash_mod_q  = ModulusReset;
  logic [HashW-1:0] run_hash    = '0;

  // Results still owed by the unit, oldest first.
  out_item_t pending_hashes [$];

  // Shared knobs: steady_flow switches off idling on both sides for a whole
  // phase; hold_wanted asks the receiver for one long hold-off.
  logic steady_flow = 1'b0;
  logic hold_wanted = 1'b0;
  logic hold_served = 1'b0;

  int unsigned bytes_sent  = 0;
  int unsigned hashes_seen = 0;
  int unsigned finals_seen = 0;
  int unsigned reg_writes  = 0;
  int unsigned phases      = 0;
  int unsigned errors      = 0;
  int unsigned cycles      = 0;

  // One Horner step. The modular product is formed at full 128-bit width and
  // then reduced, which gives the same value as any overflow-safe
  // shift-and-add scheme. The addition is done at 65 bits for the same reason.
  function automatic logic [HashW-1:0] horner_step(input logic [HashW-1:0] acc,
                                                   input logic [HashW-1:0] base,
                                                   input logic [HashW-1:0] modulus,
                                                   input logic [ByteW-1:0] b);
    logic [2*HashW-1:0] prod;
    logic [HashW:0]     sum;
    if (modulus == '0) begin
      return acc * base + HashW'(b);
    end
    prod = (2*HashW)'(acc) * (2*HashW)'(base);
    prod = prod % (2*HashW)'(modulus);
    sum  = (HashW+1)'(prod[HashW-1:0]) + (HashW+1)'(b);
    sum  = sum % (HashW+1)'(modulus);
    return sum[HashW-1:0];
  endfunction

  // Offers one byte after a random gap and records the hash it must produce.
  // When typed is set the hand-worked hash is expected instead of the
  // predicted one; the predictor still moves its own state on.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic l,
                           input logic typed, input logic [HashW-1:0] typed_hash);
    int unsigned      gap;
    logic [HashW-1:0] next;
    out_item_t        want;
    gap = steady_flow ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: l};
    do @(posedge clk); while (in_stall);
    next            = horner_step(run_hash, hash_base_q, hash_mod_q, b);
    want.hash_value = typed ? typed_hash : next;
    want.hash_final = l;
    pending_hashes.push_back(want);
    run_hash = l ? '0 : next;
    bytes_sent++;
  endtask

  // Drops the byte stream and waits until every owed result has arrived, so
  // that the unit is idle before its registers are touched.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
  endtask

  // Register write. The valid is left high so that back-to-back writes do
  // not drop it; the caller lowers it after the last write of a group.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [HashW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CfgIdxBase) begin
      hash_base_q = value;
    end else if (idx == CfgIdxModulus) begin
      hash_mod_q = value;
    end
    reg_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Result side. Outside steady phases the receiver stalls before every
  // result for a random number of cycles, so the stall lands on every phase
  // of the unit's work. Once, on request, it holds off at length while bytes
  // keep coming, which fills the unit and pushes the stall onto the byte stream.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    out_item_t   want;
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, 16);
      if (hold_wanted && !hold_served) begin
        hold        = LongHold;
        hold_served = 1'b1;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      hashes_seen++;
      if (out_data.hash_final) finals_seen++;
      if (pending_hashes.size() == 0) begin
        $error("unexpected result: hash_value %h hash_final %b",
               out_data.hash_value, out_data.hash_final);
        errors++;
      end else begin
        want = pending_hashes.pop_front();
        if (out_data.hash_value !== want.hash_value) begin
          $error("hash_value: expected %h, got %h", want.hash_value, out_data.hash_value);
          errors++;
        end
        if (out_data.hash_final !== want.hash_final) begin
          $error("hash_final: expected %b, got %b", want.hash_final, out_data.hash_final);
          errors++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results owed.",
               cycles, pending_hashes.size());
      $display("FAIL polynomial_rolling_hash_unit");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: the directed table first, then random phases. Each phase opens
  // on an idle unit with fresh register settings; a phase may well end in the
  // middle of a message, so the next settings apply to a live running hash.
  // --------------------------------------------------------------------------
  initial begin
    logic             in_reg_group;
    int unsigned      random_sent;
    int unsigned      phase_len;
    int unsigned      pick;
    logic [HashW-1:0] value;
    logic [ByteW-1:0] b;
    in_reg_group = 1'b0;
    random_sent  = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        if (!in_reg_group) begin
          wait_idle();
          in_reg_group = 1'b1;
        end
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        if (in_reg_group) begin
          cfg_valid    <= 1'b0;
          in_reg_group = 1'b0;
        end
        send_byte(dir_rows[i].data, dir_rows[i].last,
                  dir_rows[i].typed, dir_rows[i].typed_hash);
      end
    end

    // Random phases. The very first runs without idling and asks for the
    // long receiver hold-off, so the sender really does press against it.
    while (random_sent < RandomBytes) begin
      wait_idle();
      phases++;

      pick = $urandom_range(0, 3);
      if (pick != 1) begin
        case ($urandom_range(0, 7))
          0:       value = '0;
          1:       value = 64'd1;
          2:       value = BaseReset;
          3:       value = AllOnes;
          4:       value = 64'($urandom_range(2, 1000));
          5:       value = 64'd1 << $urandom_range(0, HashW-1);
          default: value = {$urandom, $urandom};
        endcase
        write_reg(CfgIdxBase, value);
      end
      if (pick != 0) begin
        case ($urandom_range(0, 9))
          0, 1:    value = '0;
          2:       value = 64'd1;
          3:       value = AllOnes;
          4:       value = TopBit;
          5:       value = 64'($urandom_range(2, 300));
          6:       value = 64'($urandom);
          default: value = {$urandom, $urandom};
        endcase
        write_reg(CfgIdxModulus, value);
      end
      if ($urandom_range(0, 5) == 0) begin
        write_reg($urandom_range(0, 1) ? CfgIdxSpare2 : CfgIdxSpare3, {$urandom, $urandom});
      end
      cfg_valid <= 1'b0;

      steady_flow = (phases == 1) || ($urandom_range(0, 3) == 0);
      hold_wanted = (phases == 1);

      // Messages average about six bytes; byte values lean on the extremes.
      phase_len = $urandom_range(20, 60);
      repeat (phase_len) begin
        case ($urandom_range(0, 7))
          0:       b = '0;
          1:       b = '1;
          default: b = ByteW'($urandom);
        endcase
        send_byte(b, $urandom_range(0, 5) == 0, 1'b0, '0);
        random_sent++;
      end
    end

    wait_idle();
    repeat (SettleWait) @(posedge clk);

    $display("Covered %0d bytes in %0d random phases after the directed table.",
             bytes_sent, phases);
    $display("Checked %0d hashes (%0d message ends) across %0d register writes.",
             hashes_seen, finals_seen, reg_writes);
    if (errors == 0) begin
      $display("PASS polynomial_rolling_hash_unit");
    end else begin
      $display("FAIL polynomial_rolling_hash_unit");
    end
    $finish;
  end

endmodule

[files.f]
rtl/prh_pkg.sv
rtl/prh_modadd.sv
rtl/prh_engine.sv
rtl/polynomial_rolling_hash_unit.sv
tb/sv/tb_polynomial_rolling_hash_unit.sv
